/* rtl/core/pwlop_pkg.sv */
// Shared types and constants for the piecewise-linear opacity table.
package pwlop_pkg;

   localparam int ONE_Q12 = 4096;
   localparam int X_W     = 22;
   localparam int DIV_N   = 33;
   localparam int DIV_D   = 16;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_CLEAR  = 2'd1,
      FUNC_EVAL   = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CHK,
      S_EV_RD,
      S_EV_CHK,
      S_EV_MUL,
      S_EV_DIV,
      S_EV_FIN,
      S_OUT
   } state_type;

   typedef struct packed {
      logic signed [15:0] pos;
      logic signed [15:0] level;
   } point_type;

endpackage

/* rtl/core/piecewise_linear_opacity_lut_top.sv */
// Piecewise-linear opacity table: sorted point memory, segment scan, serial divider.
// Insert: the shift loop moves larger points up one slot at a time, then writes the new point.
// Evaluate: scans the segments in order, then multiplies and runs the one-bit-a-cycle divider;
// the divider is skipped when the result is an end point or the sample lands on a point.
// Clear, empty or full cases go straight to the output. One item at a time; a result waits in the output register.
// Synchronous reset empties the table; point memory contents stay undefined until written.
module piecewise_linear_opacity_lut_top
   import pwlop_pkg::*;
#(
   parameter int MAX_POINTS = 16,
   parameter int MAP_SIZE   = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_alpha,
   input  logic [7:0]         req_sample_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [12:0]        rsp_opacity,
   output logic [1:0]         rsp_status
);

   localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int M1     = MAP_SIZE - 1;
   localparam int STEP_W = $clog2(DIV_N + 1);

   point_type mem [MAX_POINTS];
   point_type rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   logic [IDX_W-1:0] wr_addr;
   point_type        wr_data;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   point_type        new_ff, new_in;
   point_type        prev_ff, prev_in;
   logic signed [X_W-1:0] x_ff, x_in;
   logic [DIV_N-1:0] num_ff, num_in;
   logic [DIV_D-1:0] den_ff, den_in;
   logic [DIV_D:0]   rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIV_D-1:0] dx_ff, dx_in;
   logic [DIV_D-1:0] da_ff, da_in;
   logic             neg_ff, neg_in;
   logic             eq_ff, eq_in;
   logic signed [17:0] level_ff, level_in;
   logic [12:0]      res_op_ff, res_op_in;
   status_type       res_st_ff, res_st_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [12:0]      rsp_op_ff, rsp_op_in;
   logic [1:0]       rsp_st_ff, rsp_st_in;

   logic             req_fire;
   logic [DIV_D:0]   rem_shift;
   logic             rem_ge;
   logic signed [X_W-1:0] cur_pos_x;
   logic signed [16:0] den_s, da_s;
   logic             last_k;
   logic [2*DIV_D-1:0] prod;
   wire  [X_W-1:0]   xpos_tbl [256];

   for (genvar gi = 0; gi < 256; gi++) begin : g_xpos
      assign xpos_tbl[gi] = X_W'((gi * 8192 + M1) / (2 * M1));
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff   <= slot_in;
      new_ff    <= new_in;
      prev_ff   <= prev_in;
      x_ff      <= x_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      step_ff   <= step_in;
      dx_ff     <= dx_in;
      da_ff     <= da_in;
      neg_ff    <= neg_in;
      eq_ff     <= eq_in;
      level_ff  <= level_in;
      res_op_ff <= res_op_in;
      res_st_ff <= res_st_in;
      rsp_op_ff <= rsp_op_in;
      rsp_st_ff <= rsp_st_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign req_fire    = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_opacity = rsp_op_ff;
   assign rsp_status  = rsp_st_ff;

   assign rem_shift = {rem_ff[DIV_D-1:0], num_ff[DIV_N-1]};
   assign rem_ge    = (rem_shift >= {1'b0, den_ff});
   assign cur_pos_x = X_W'(rd_data_ff.pos);
   assign den_s     = 17'(rd_data_ff.pos) - 17'(prev_ff.pos);
   assign da_s      = 17'(rd_data_ff.level) - 17'(prev_ff.level);
   assign last_k    = ((CNT_W'(slot_ff) + CNT_W'(1)) == count_ff);
   assign prod      = dx_ff * da_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      new_in       = new_ff;
      prev_in      = prev_ff;
      x_in         = x_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      dx_in        = dx_ff;
      da_in        = da_ff;
      neg_in       = neg_ff;
      eq_in        = eq_ff;
      level_in     = level_ff;
      res_op_in    = res_op_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_op_in    = rsp_op_ff;
      rsp_st_in    = rsp_st_ff;
      rd_addr      = slot_ff;
      mem_we       = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = new_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_op_in  = '0;
               res_st_in  = STATUS_OK;
               new_in.pos   = req_point_x;
               new_in.level = req_point_alpha;
               slot_in    = IDX_W'(count_ff);
               state_in   = S_OUT;
               case (func_type'(req_func))
                  FUNC_INSERT: begin
                     if (count_ff == CNT_W'(MAX_POINTS)) begin
                        res_st_in = STATUS_FULL;
                     end else begin
                        state_in = S_INS_RD;
                     end
                  end
                  FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  FUNC_EVAL: begin
                     if (count_ff == '0) begin
                        res_st_in = STATUS_EMPTY;
                     end else begin
                        x_in     = xpos_tbl[req_sample_index];
                        slot_in  = '0;
                        eq_in    = 1'b0;
                        state_in = S_EV_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INS_RD: begin
            if (slot_ff == '0) begin
               mem_we   = 1'b1;
               count_in = count_ff + CNT_W'(1);
               state_in = S_OUT;
            end else begin
               rd_addr  = slot_ff - IDX_W'(1);
               state_in = S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            mem_we = 1'b1;
            if (rd_data_ff.pos > new_ff.pos) begin
               wr_data  = rd_data_ff;
               slot_in  = slot_ff - IDX_W'(1);
               state_in = S_INS_RD;
            end else begin
               count_in = count_ff + CNT_W'(1);
               state_in = S_OUT;
            end
         end
         S_EV_DIV: begin
            rem_in  = rem_ge ? (rem_shift - {1'b0, den_ff}) : rem_shift;
            num_in  = {num_ff[DIV_N-2:0], rem_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_N - 1)) begin
               level_in = neg_ff ? (18'(prev_ff.level) - 18'(num_in[16:0]))
                                 : (18'(prev_ff.level) + 18'(num_in[16:0]));
               state_in = S_EV_FIN;
            end
         end
         S_EV_RD: begin
            rd_addr  = slot_ff;
            state_in = S_EV_CHK;
         end
         S_EV_CHK: begin
            if (eq_ff) begin
               if (x_ff != cur_pos_x) begin
                  state_in = S_EV_FIN;
               end else if (last_k) begin
                  level_in = 18'(rd_data_ff.level);
                  state_in = S_EV_FIN;
               end else begin
                  slot_in  = slot_ff + IDX_W'(1);
                  state_in = S_EV_RD;
               end
            end else if (x_ff <= cur_pos_x) begin
               if (slot_ff == '0) begin
                  level_in = 18'(rd_data_ff.level);
                  state_in = S_EV_FIN;
               end else if (x_ff == cur_pos_x) begin
                  level_in = 18'(rd_data_ff.level);
                  if (last_k) begin
                     state_in = S_EV_FIN;
                  end else begin
                     eq_in    = 1'b1;
                     slot_in  = slot_ff + IDX_W'(1);
                     state_in = S_EV_RD;
                  end
               end else begin
                  dx_in    = DIV_D'(x_ff - X_W'(prev_ff.pos));
                  den_in   = den_s[DIV_D-1:0];
                  neg_in   = da_s[16];
                  da_in    = da_s[16] ? DIV_D'(-da_s) : da_s[DIV_D-1:0];
                  state_in = S_EV_MUL;
               end
            end else if (last_k) begin
               level_in = 18'(rd_data_ff.level);
               state_in = S_EV_FIN;
            end else begin
               prev_in  = rd_data_ff;
               slot_in  = slot_ff + IDX_W'(1);
               state_in = S_EV_RD;
            end
         end
         S_EV_MUL: begin
            num_in   = DIV_N'(prod) + DIV_N'(den_ff >> 1);
            rem_in   = '0;
            step_in  = '0;
            state_in = S_EV_DIV;
         end
         S_EV_FIN: begin
            if (level_ff < 0) begin
               res_op_in = '0;
            end else if (level_ff > 18'(ONE_Q12)) begin
               res_op_in = 13'(ONE_Q12);
            end else begin
               res_op_in = level_ff[12:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_op_in    = res_op_ff;
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count above capacity");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_func == FUNC_CLEAR |=> count_ff == '0)
      else $error("clear left points");

   a_opacity_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_opacity != '0 |-> rsp_status == STATUS_OK)
      else $error("opacity with error status");

   a_opacity_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_opacity <= 13'(ONE_Q12))
      else $error("opacity out of range");

endmodule

/* dv/tb_piecewise_linear_opacity_lut_top.sv */
// Self-checking testbench for the piecewise-linear opacity table.
`timescale 1ns / 100ps
module tb_piecewise_linear_opacity_lut_top;
   import pwlop_pkg::*;

   localparam int NPTS = 16;
   localparam int NMAP = 256;
   localparam int CYCLE_LIMIT = 1000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func = FUNC_NONE;
   logic signed [15:0] req_point_x = '0;
   logic signed [15:0] req_point_alpha = '0;
   logic [7:0]         req_sample_index = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [12:0]        rsp_opacity;
   logic [1:0]         rsp_status;

   piecewise_linear_opacity_lut_top #(.MAX_POINTS(NPTS), .MAP_SIZE(NMAP)) uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic [12:0] opacity;
      logic [1:0]  status;
   } opacity_result_t;

   opacity_result_t expected_q[$];
   int mismatches = 0;
   int cycles = 0;
   bit idle_on = 1'b1;

   int signed tbl_pos[NPTS];
   int signed tbl_level[NPTS];
   int tbl_count = 0;

   function automatic int signed seg_level(int signed x, int signed x0, int signed a0,
                                           int signed x1, int signed a1);
      longint den, dx, da, mag, q;
      den = x1 - x0;
      dx = x - x0;
      da = a1 - a0;
      if (den <= 0) return a0;
      mag = dx * (da < 0 ? -da : da);
      q = (mag + den / 2) / den;
      return da < 0 ? a0 - q : a0 + q;
   endfunction

   function automatic logic [12:0] map_opacity(int unsigned idx);
      int signed x, lvl;
      int m1;
      m1 = NMAP - 1;
      x = (idx * 4096 * 2 + m1) / (2 * m1);
      lvl = 0;
      if (x <= tbl_pos[0]) lvl = tbl_level[0];
      else if (x >= tbl_pos[tbl_count-1]) lvl = tbl_level[tbl_count-1];
      else begin
         for (int j = 0; j + 1 < tbl_count; j++) begin
            if (x >= tbl_pos[j] && x <= tbl_pos[j+1]) begin
               lvl = seg_level(x, tbl_pos[j], tbl_level[j], tbl_pos[j+1], tbl_level[j+1]);
               break;
            end
         end
      end
      if (lvl < 0) lvl = 0;
      if (lvl > ONE_Q12) lvl = ONE_Q12;
      return lvl[12:0];
   endfunction

   function automatic opacity_result_t table_step(logic [1:0] f, logic signed [15:0] px,
                                                  logic signed [15:0] pa, logic [7:0] si);
      opacity_result_t r;
      int slot;
      r = '{opacity: '0, status: STATUS_OK};
      case (f)
         FUNC_INSERT: begin
            if (tbl_count >= NPTS) r.status = STATUS_FULL;
            else begin
               slot = tbl_count;
               while (slot > 0 && tbl_pos[slot-1] > px) begin
                  tbl_pos[slot] = tbl_pos[slot-1];
                  tbl_level[slot] = tbl_level[slot-1];
                  slot--;
               end
               tbl_pos[slot] = px;
               tbl_level[slot] = pa;
               tbl_count++;
            end
         end
         FUNC_CLEAR: tbl_count = 0;
         FUNC_EVAL: begin
            if (tbl_count == 0) r.status = STATUS_EMPTY;
            else r.opacity = map_opacity(si);
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_item(logic [1:0] f, logic signed [15:0] px = 0,
                            logic signed [15:0] pa = 0, logic [7:0] si = 0);
      while (idle_on && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_func <= f;
      req_point_x <= px;
      req_point_alpha <= pa;
      req_sample_index <= si;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q = {expected_q, table_step(f, px, pa, si)};
      @(negedge clock);
   endtask

   always @(negedge clock)
      if (!reset) rsp_stall <= idle_on && ($urandom_range(99) < 31);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: opacity %0d status %0d",
                                           rsp_opacity, rsp_status);
         end else begin
            opacity_result_t e;
            e = expected_q.pop_front();
            if (e.opacity !== rsp_opacity || e.status !== rsp_status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected opacity %0d status %0d, got %0d %0d",
                           e.opacity, e.status, rsp_opacity, rsp_status);
            end
         end
      end
   end

   function automatic logic signed [15:0] near_unit();
      return $urandom_range(2) == 0 ? 16'($urandom) : 16'($signed($urandom_range(5000)) - 400);
   endfunction

   task automatic test_extremes();
      send_item(FUNC_EVAL, 0, 0, 8'd0);
      send_item(FUNC_INSERT, 16'sh8000, 16'sh7fff);
      send_item(FUNC_INSERT, 16'sh7fff, 16'sh8000);
      send_item(FUNC_EVAL, 0, 0, 8'd0);
      send_item(FUNC_EVAL, 0, 0, 8'd255);
      send_item(FUNC_EVAL, 0, 0, 8'd128);
      send_item(FUNC_NONE, 16'sh7fff, 16'sh7fff, 8'hff);
      send_item(FUNC_CLEAR);
      send_item(FUNC_EVAL, 0, 0, 8'd10);
   endtask

   task automatic test_segments();
      send_item(FUNC_INSERT, 16'sd2048, 16'sd0);
      send_item(FUNC_INSERT, 16'sd1024, 16'sd4096);
      send_item(FUNC_INSERT, 16'sd2048, 16'sd1000);
      send_item(FUNC_INSERT, 16'sd3000, 16'sd2000);
      for (int i = 0; i < 256; i += 37) send_item(FUNC_EVAL, 0, 0, i[7:0]);
      send_item(FUNC_EVAL, 0, 0, 8'd128);
   endtask

   task automatic test_full_table();
      send_item(FUNC_CLEAR);
      for (int i = 0; i < NPTS + 2; i++)
         send_item(FUNC_INSERT, 16'(i * 256), 16'($urandom_range(4096)));
      send_item(FUNC_EVAL, 0, 0, 8'd255);
   endtask

   task automatic test_random(int n);
      int k;
      k = 0;
      while (k < n) begin
         send_item(FUNC_CLEAR);
         k++;
         for (int p = $urandom_range(NPTS + 2); p > 0; p--) begin
            send_item(FUNC_INSERT, near_unit(), near_unit());
            k++;
         end
         for (int e = $urandom_range(1, 12); e > 0; e--) begin
            if ($urandom_range(9) == 0)
               send_item(2'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
            else send_item(FUNC_EVAL, 0, 0, 8'($urandom));
            k++;
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_segments();
      test_full_table();
      test_random(900);
      idle_on = 1'b0;
      test_random(300);
      idle_on = 1'b1;
      test_random(600);
      drain();
      if (mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   final if (expected_q.size() != 0) mismatches++;
endmodule

/* sim.f */
rtl/core/pwlop_pkg.sv
rtl/core/piecewise_linear_opacity_lut_top.sv
dv/tb_piecewise_linear_opacity_lut_top.sv
